// ===== design/lkc_pkg.sv =====
// Shared types and constants for the keyed LRU cache.
package lkc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [2:0] ADDR_CAPACITY = 3'd0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_INVAL = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef enum logic [3:0] {
    OP_LOOKUP = 4'b0001,
    OP_STORE  = 4'b0010,
    OP_INVAL  = 4'b0100,
    OP_NOP    = 4'b1000
  } lkc_op_t;

  typedef struct packed {
    logic [15:0] asset_id;
    logic [23:0] start_frame;
    logic [23:0] duration;
    logic [15:0] pixel_width;
    logic [9:0]  frame_rate;
  } lkc_key_t;

  typedef struct packed {
    lkc_op_t     op;
    lkc_key_t    key;
    logic [15:0] payload;
  } lkc_item_t;

endpackage

// ===== design/lkc_front.sv =====
// Front end: decode incoming requests and queue them for the engine.
module lkc_front
  import lkc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_asset_id,
  input  logic [23:0] in_start_frame,
  input  logic [23:0] in_duration,
  input  logic [15:0] in_pixel_width,
  input  logic [9:0]  in_frame_rate,
  input  logic [15:0] in_payload_in,
  output logic        q_valid,
  output lkc_item_t   q_item,
  input  logic        q_pop
);

  lkc_item_t            q_mem [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]    cnt_r;
  lkc_item_t            dec;
  logic                 push;

  always_comb begin
    case (in_req_type)
      REQ_LOOKUP: dec.op = OP_LOOKUP;
      REQ_STORE:  dec.op = OP_STORE;
      REQ_INVAL:  dec.op = OP_INVAL;
      default:    dec.op = OP_NOP;
    endcase
    dec.key.asset_id    = in_asset_id;
    dec.key.start_frame = in_start_frame;
    dec.key.duration    = in_duration;
    dec.key.pixel_width = in_pixel_width;
    dec.key.frame_rate  = in_frame_rate;
    dec.payload         = in_payload_in;
  end

  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== design/lkc_back.sv =====
// Back end: walk the entries, update recency, evict, insert and report.
module lkc_back
  import lkc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  lkc_item_t         q_item,
  output logic              q_pop,
  input  logic [CAP_W-1:0]  cap_eff,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_key_found,
  output logic [15:0]       out_payload_out,
  output logic [4:0]        out_entry_count
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_TOUCH  = 6'b000100,
    S_EVICT  = 6'b001000,
    S_INSERT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  lkc_item_t              item_r, item_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [IDX_W-1:0]       hit_r, hit_nxt;
  logic                   found_r, found_nxt;
  logic [15:0]            pay_r, pay_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   valid_r [CACHE_ENTRIES];
  logic                   valid_nxt [CACHE_ENTRIES];
  logic [IDX_W-1:0]       rank_r [CACHE_ENTRIES];
  logic [IDX_W-1:0]       rank_nxt [CACHE_ENTRIES];
  lkc_key_t               key_mem [CACHE_ENTRIES];
  logic [15:0]            pay_mem [CACHE_ENTRIES];
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [15:0]            out_pay_r;
  logic [CNT_W-1:0]       out_cnt_r;
  logic                   out_load;
  logic                   key_wr, pay_wr;
  logic [IDX_W-1:0]       wr_idx;
  logic                   last;
  logic                   cur_vld;
  logic [IDX_W-1:0]       cur_rank;
  logic                   evict_go;
  logic [IDX_W-1:0]       victim, slot;

  assign last     = (idx_r == IDX_W'(CACHE_ENTRIES - 1));
  assign cur_vld  = valid_r[idx_r];
  assign cur_rank = rank_r[idx_r];
  assign evict_go = ({{(CNT_W-CAP_W){1'b0}}, cap_eff} <= count_r) && (count_r != '0);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Least-recent valid entry and first free slot.
  always_comb begin
    victim = '0;
    slot   = '0;
    for (int j = CACHE_ENTRIES - 1; j >= 0; j--) begin
      if (valid_r[j] && ({1'b0, rank_r[j]} == count_r - CNT_W'(1))) victim = IDX_W'(j);
      if (!valid_r[j]) slot = IDX_W'(j);
    end
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    found_nxt = found_r;
    pay_nxt   = pay_r;
    count_nxt = count_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    q_pop     = 1'b0;
    key_wr    = 1'b0;
    pay_wr    = 1'b0;
    wr_idx    = hit_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          pay_nxt   = '0;
          state_nxt = (q_item.op == OP_NOP) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (item_r.op == OP_INVAL) begin
          if (cur_vld && key_mem[idx_r].asset_id == item_r.key.asset_id) begin
            valid_nxt[idx_r] = 1'b0;
            count_nxt = count_r - CNT_W'(1);
            for (int j = 0; j < CACHE_ENTRIES; j++) begin
              if (valid_r[j] && rank_r[j] > cur_rank) rank_nxt[j] = rank_r[j] - 1'b1;
            end
          end
          if (last) state_nxt = S_DONE;
          else idx_nxt = idx_r + 1'b1;
        end else if (cur_vld && key_mem[idx_r] == item_r.key) begin
          hit_nxt   = idx_r;
          found_nxt = 1'b1;
          state_nxt = S_TOUCH;
        end else if (last) begin
          state_nxt = (item_r.op == OP_STORE) ? S_EVICT : S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TOUCH: begin
        for (int j = 0; j < CACHE_ENTRIES; j++) begin
          if (valid_r[j] && rank_r[j] < rank_r[hit_r]) rank_nxt[j] = rank_r[j] + 1'b1;
        end
        rank_nxt[hit_r] = '0;
        if (item_r.op == OP_STORE) begin
          pay_wr  = 1'b1;
          pay_nxt = item_r.payload;
        end else begin
          pay_nxt = pay_mem[hit_r];
        end
        state_nxt = S_DONE;
      end
      S_EVICT: begin
        // Drop the least-recent entry one at a time until below capacity.
        if (evict_go) begin
          valid_nxt[victim] = 1'b0;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        for (int j = 0; j < CACHE_ENTRIES; j++) begin
          if (valid_r[j]) rank_nxt[j] = rank_r[j] + 1'b1;
        end
        valid_nxt[slot] = 1'b1;
        rank_nxt[slot]  = '0;
        count_nxt = count_r + CNT_W'(1);
        key_wr    = 1'b1;
        pay_wr    = 1'b1;
        wr_idx    = slot;
        pay_nxt   = item_r.payload;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_wr) key_mem[wr_idx] <= item_r.key;
    if (pay_wr) pay_mem[wr_idx] <= item_r.payload;
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    idx_r   <= idx_nxt;
    hit_r   <= hit_nxt;
    found_r <= found_nxt;
    pay_r   <= pay_nxt;
    if (out_load) begin
      out_found_r <= found_r;
      out_pay_r   <= pay_r;
      out_cnt_r   <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < CACHE_ENTRIES; j++) begin
        valid_r[j] <= 1'b0;
        rank_r[j]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_found   = out_found_r;
  assign out_payload_out = out_pay_r;
  assign out_entry_count = 5'(out_cnt_r);

endmodule

// ===== design/lru_keyed_cache_with_group_invalidate_unit.sv =====
// Top level of the keyed LRU cache with asset-wide invalidate.
//
// Fully associative 16-entry LRU cache keyed on asset id, start frame, duration,
// pixel width and frame rate, each entry holding a 16-bit payload handle. One result
// item comes back per request item. A request is decoded and queued (two deep) by the
// front end; the back-end engine walks the entries one per cycle. A lookup or store
// scans the entries, stopping at the first hit; the engine also takes the item from
// the queue, updates recency on a hit and hands the result over. An invalidate always
// walks all 16 entries. A store of a new key walks all entries, then drops one
// least-recent entry per cycle until below capacity and then inserts the new key.
// Capacity is written at byte address 0: 0 acts as 1, above 16 as 16. The queue
// keeps accepting items while it is not full, also while the engine works or a
// result waits.
module lru_keyed_cache_with_group_invalidate_unit
  import lkc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_asset_id,
  input  logic [23:0] in_start_frame,
  input  logic [23:0] in_duration,
  input  logic [15:0] in_pixel_width,
  input  logic [9:0]  in_frame_rate,
  input  logic [15:0] in_payload_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_key_found,
  output logic [15:0] out_payload_out,
  output logic [4:0]  out_entry_count
);

  logic [CAP_W-1:0] capacity_r;
  logic [CAP_W-1:0] cap_eff;
  logic             q_valid, q_pop;
  lkc_item_t        q_item;

  assign pready = 1'b1;
  assign prdata = {{(32-CAP_W){1'b0}}, capacity_r};

  // Take capacity on the access phase of a write to its address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  // Clamp capacity into 1..CACHE_ENTRIES.
  always_comb begin
    if (capacity_r == '0) cap_eff = CAP_W'(1);
    else if (capacity_r > CAP_W'(CACHE_ENTRIES)) cap_eff = CAP_W'(CACHE_ENTRIES);
    else cap_eff = capacity_r;
  end

  lkc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_asset_id,
    .in_start_frame, .in_duration, .in_pixel_width, .in_frame_rate,
    .in_payload_in, .q_valid, .q_item, .q_pop
  );

  lkc_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .cap_eff,
    .out_valid, .out_stall, .out_key_found, .out_payload_out, .out_entry_count
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 5'(CACHE_ENTRIES))
    else $error("entry count above cache size");

  a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_found |-> out_entry_count != 5'd0)
    else $error("hit reported on empty cache");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule
